FILE: rtl/dngr_pkg.sv
// ----------------------------------------------------------------------------
// dngr_pkg
// Types, constants and the digit glyph table for the decimal glyph renderer.
// ----------------------------------------------------------------------------
package dngr_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int VALUE_BITS_DEF = 32;
  localparam int BITS_PER_STAGE = 4;
  localparam int NUMBER_W       = 32;
  localparam int COORD_W        = 12;
  localparam int PIXEL_X_W      = 13;
  localparam int GLYPH_W        = 64;
  localparam int COLOR_W        = 32;

  localparam logic [PIXEL_X_W-1:0] DIGIT_PITCH  = 13'd9;
  localparam logic [COLOR_W-1:0]   COLOR_RESET  = 32'h00FF_FFFF;
  localparam logic [3:0]           BCD_ADJ_MIN  = 4'd5;
  localparam logic [3:0]           BCD_ADJ      = 4'd3;
  localparam logic [3:0]           DIGIT_MAX    = 4'd9;

  typedef struct packed {
    logic [NUMBER_W-1:0] number_value;
    logic [COORD_W-1:0]  origin_x;
    logic [COORD_W-1:0]  origin_y;
  } in_req_t;

  typedef struct packed {
    logic [3:0]           digit;
    logic [GLYPH_W-1:0]   glyph_bits;
    logic [PIXEL_X_W-1:0] pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic                 last_digit;
  } out_req_t;

  function automatic logic [GLYPH_W-1:0] digit_glyph(input logic [3:0] d);
    logic [GLYPH_W-1:0] g;
    unique case (d)
      4'd0:    g = 64'h7CC6_CEDE_F6E6_C67C;
      4'd1:    g = 64'h1838_7818_1818_187E;
      4'd2:    g = 64'h7CC6_060C_1830_60FE;
      4'd3:    g = 64'h7CC6_063C_0606_C67C;
      4'd4:    g = 64'h0C1C_3C6C_CCFE_0C0C;
      4'd5:    g = 64'hFEC0_C0FC_0606_C67C;
      4'd6:    g = 64'h3C60_C0FC_C6C6_C67C;
      4'd7:    g = 64'hFEC6_0C18_3030_3030;
      4'd8:    g = 64'h7CC6_C67C_C6C6_C67C;
      4'd9:    g = 64'h7CC6_C67E_0606_0C78;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/decimal_number_glyph_renderer.sv
// ----------------------------------------------------------------------------
// decimal_number_glyph_renderer
// Binary to decimal converter that emits one glyph request per digit.
// ----------------------------------------------------------------------------
// Usage:
//   src channel (src_valid/src_stall/src_req) takes a value and a screen
//   origin. dst channel (dst_valid/dst_stall/dst_req) returns one request per
//   decimal digit, most significant first, with its 8x8 glyph, pixel position
//   and a last flag on the final digit. Zero gives the single digit 0.
//   cfg_write/cfg_data load text_color, held for the pixel writer.
// Timing:
//   Conversion is a shift-add-3 pipeline of ceil(VALUE_BITS/4) stages, four
//   bits per stage (8 at defaults), followed by the digit count register,
//   the digit emitter and the output register. The digit emitter issues one
//   digit per cycle while dst_stall is low; the pipeline accepts a request
//   every cycle until the emitter backs up.
// Reset and flow control:
//   rst clears all valid bits and sets text_color to 0x00FFFFFF.
//   dst_stall freezes the output register; the backlog fills the stages and
//   then raises src_stall. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module decimal_number_glyph_renderer #(
  parameter int MAX_DIGITS = dngr_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = dngr_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         src_valid,
  output logic                         src_stall,
  input  dngr_pkg::in_req_t            src_req,
  output logic                         dst_valid,
  input  logic                         dst_stall,
  output dngr_pkg::out_req_t           dst_req,
  input  logic                         cfg_write,
  input  logic [dngr_pkg::COLOR_W-1:0] cfg_data
);
  import dngr_pkg::*;

  localparam int NS   = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int ND   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCDW = 4 * ND;
  localparam int KD   = MAX_DIGITS;
  localparam int IW   = (KD > 1) ? $clog2(KD) : 1;

  logic [COLOR_W-1:0] text_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (cfg_write) begin
      text_color <= cfg_data;
    end
  end

  // conversion pipeline
  logic                  pv   [0:NS];
  logic                  rdy  [0:NS];
  logic [BCDW-1:0]       pbcd [0:NS];
  logic [VALUE_BITS-1:0] pbin [0:NS];
  logic [COORD_W-1:0]    px   [0:NS];
  logic [COORD_W-1:0]    py   [0:NS];

  logic                  c_ready;
  logic [63:0]           value_wide;

  assign value_wide = 64'(src_req.number_value);
  assign src_stall  = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (rdy[0]) begin
      pv[0] <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && src_valid) begin
      pbcd[0] <= '0;
      pbin[0] <= value_wide[VALUE_BITS-1:0];
      px[0]   <= src_req.origin_x;
      py[0]   <= src_req.origin_y;
    end
  end

  for (genvar r = 0; r <= NS; r++) begin : g_rdy
    if (r < NS) begin : g_mid
      assign rdy[r] = !pv[r] || rdy[r+1];
    end else begin : g_end
      assign rdy[r] = !pv[r] || c_ready;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int BASE = s * BITS_PER_STAGE;
    logic [BCDW-1:0]       nb;
    logic [VALUE_BITS-1:0] nv;

    always_comb begin
      nb = pbcd[s];
      nv = pbin[s];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        if (BASE + j < VALUE_BITS) begin
          for (int d = 0; d < ND; d++) begin
            if (nb[4*d +: 4] >= BCD_ADJ_MIN) begin
              nb[4*d +: 4] = nb[4*d +: 4] + BCD_ADJ;
            end
          end
          nb = {nb[BCDW-2:0], nv[VALUE_BITS-1]};
          nv = {nv[VALUE_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[s+1] <= 1'b0;
      end else if (rdy[s+1]) begin
        pv[s+1] <= pv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s+1] && pv[s]) begin
        pbcd[s+1] <= nb;
        pbin[s+1] <= nv;
        px[s+1]   <= px[s];
        py[s+1]   <= py[s];
      end
    end
  end

  // digit count stage
  logic [4*(ND+KD)-1:0] bcd_pad;
  logic                 over;
  logic [3:0]           kept   [0:KD-1];
  logic [IW-1:0]        hi;
  logic                 cv;
  logic [3:0]           c_digits [0:KD-1];
  logic [IW-1:0]        c_hi;
  logic [COORD_W-1:0]   c_x;
  logic [COORD_W-1:0]   c_y;
  logic                 e_ready;

  assign bcd_pad = {{(4*KD){1'b0}}, pbcd[NS]};
  assign over    = |bcd_pad[4*KD +: 4*ND];
  assign c_ready = !cv || e_ready;

  // more digits than MAX_DIGITS: emit all of the kept low digits
  always_comb begin
    hi = '0;
    for (int i = 0; i < KD; i++) begin
      kept[i] = bcd_pad[4*i +: 4];
      if (kept[i] != 4'd0) begin
        hi = IW'(i);
      end
    end
    if (over) begin
      hi = IW'(KD - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (c_ready) begin
      cv <= pv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && pv[NS]) begin
      c_digits <= kept;
      c_hi     <= hi;
      c_x      <= px[NS];
      c_y      <= py[NS];
    end
  end

  // digit emitter
  logic                 e_valid;
  logic [3:0]           e_digits [0:KD-1];
  logic [IW-1:0]        e_idx;
  logic [PIXEL_X_W-1:0] e_x;
  logic [COORD_W-1:0]   e_y;
  logic                 fire;
  logic [3:0]           e_digit;

  assign fire    = e_valid && (!dst_valid || !dst_stall);
  assign e_ready = !e_valid || (fire && e_idx == '0);
  assign e_digit = e_digits[e_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_ready) begin
      e_valid <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && cv) begin
      e_digits <= c_digits;
      e_idx    <= c_hi;
      e_x      <= PIXEL_X_W'(c_x);
      e_y      <= c_y;
    end else if (fire) begin
      e_idx <= IW'(e_idx - 1'b1);
      e_x   <= PIXEL_X_W'(e_x + DIGIT_PITCH);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (!dst_valid || !dst_stall) begin
      dst_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dst_req.digit      <= e_digit;
      dst_req.glyph_bits <= digit_glyph(e_digit);
      dst_req.pixel_x    <= e_x;
      dst_req.pixel_y    <= e_y;
      dst_req.last_digit <= (e_idx == '0);
    end
  end

endmodule

FILE: rtl/dngr_check.sv
// ----------------------------------------------------------------------------
// dngr_check
// Port-level checks on the digit request stream of the glyph renderer.
// ----------------------------------------------------------------------------
module dngr_check (
  input logic                clk,
  input logic                rst,
  input logic                dst_valid,
  input logic                dst_stall,
  input dngr_pkg::out_req_t  dst_req
);
  import dngr_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("dst_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_req))
    else $error("stalled request changed");

  a_glyph: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> dst_req.digit <= DIGIT_MAX &&
                  dst_req.glyph_bits == digit_glyph(dst_req.digit))
    else $error("glyph does not match digit");

  // digits of one number go out back to back, one pitch apart
  a_next_digit: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_stall && !dst_req.last_digit |=>
      dst_valid &&
      dst_req.pixel_x == PIXEL_X_W'($past(dst_req.pixel_x) + DIGIT_PITCH) &&
      dst_req.pixel_y == $past(dst_req.pixel_y))
    else $error("digit sequence broken");

endmodule

bind decimal_number_glyph_renderer dngr_check u_check (.*);
